// ===== hw/rtl/accfp_pkg.sv =====
// Shared types and constants for the colon/CR/LF frame parser.
// Used by accfp_cell and ascii_colon_crlf_frame_parser_unit; no dependencies.
package accfp_pkg;

    // Payload store depth and derived widths
    localparam int MAX_PAYLOAD = 16;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int LEN_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 2;

    // Register reset values
    localparam logic [BYTE_W-1:0] START_CHAR_RST      = 8'd58;
    localparam logic [BYTE_W-1:0] FIRST_END_CHAR_RST  = 8'd13;
    localparam logic [BYTE_W-1:0] SECOND_END_CHAR_RST = 8'd10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CHAR      = 2'd0,
        CFG_FIRST_END_CHAR  = 2'd1,
        CFG_SECOND_END_CHAR = 2'd2
    } t_cfg_idx;

    // Parser phases
    typedef enum logic [1:0] {
        ST_HUNT,
        ST_DATA,
        ST_END,
        ST_EMIT
    } t_state;

    // Per-cell control: capture a received byte, or take the neighbour's byte
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/accfp_cell.sv =====
// One byte cell of the payload row: captures a received byte or takes its neighbour's.
// Depends on accfp_pkg.
module accfp_cell (
    input  logic                            i_clk,
    input  accfp_pkg::t_cell_ctl            i_ctl,
    input  logic [accfp_pkg::BYTE_W-1:0]    i_byte,
    input  logic [accfp_pkg::BYTE_W-1:0]    i_next,
    output logic [accfp_pkg::BYTE_W-1:0]    o_byte
);

    logic [accfp_pkg::BYTE_W-1:0] r_byte;
    logic [accfp_pkg::BYTE_W-1:0] n_byte;

    // Load from the input, advance from the neighbour, or hold
    always_comb begin
        n_byte = r_byte;
        if (i_ctl.load) begin
            n_byte = i_byte;
        end else if (i_ctl.shift) begin
            n_byte = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

// ===== hw/rtl/ascii_colon_crlf_frame_parser_unit.sv =====
// Top level of the colon/CR/LF frame parser: phase machine, cell row, output register.
// Depends on accfp_pkg and accfp_cell.
//
//  Channel   Dir  Beat contents
//  s_axis    in   tdata[7:0] rx_byte
//  m_axis    out  tdata[7:0] frame_byte, [12:8] payload_length; tlast is_last
//  cfg       in   i_cfg_idx selects start / first end / second end byte
//
// One received beat is taken per cycle while hunting, storing or checking the end bytes.
// A closing byte starts a drain of n+1 output beats (n stored bytes, up to 16), one per
// cycle with m_axis_tready high; the cell row advances one cell a cycle as byte beats go out; input is held.
// Reset is synchronous, active low; stored bytes are not cleared, the phase, count and index are.
// The output register lets a new input beat be taken while the closing terminator beat still waits.
module ascii_colon_crlf_frame_parser_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [accfp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [accfp_pkg::BYTE_W-1:0]          i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [accfp_pkg::BYTE_W-1:0]          s_axis_tdata,   // [7:0] rx_byte
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [accfp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [7:0] frame_byte,
                                                                  // [12:8] payload_length
    output logic                                  m_axis_tlast    // is_last
);

    localparam int N  = accfp_pkg::MAX_PAYLOAD;
    localparam int CW = accfp_pkg::CNT_W;
    localparam int BW = accfp_pkg::BYTE_W;
    localparam int LW = accfp_pkg::LEN_W;

    // Configuration registers
    logic [BW-1:0] r_start_char, r_first_end_char, r_second_end_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char      <= accfp_pkg::START_CHAR_RST;
            r_first_end_char  <= accfp_pkg::FIRST_END_CHAR_RST;
            r_second_end_char <= accfp_pkg::SECOND_END_CHAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                accfp_pkg::CFG_START_CHAR:      r_start_char      <= i_cfg_data;
                accfp_pkg::CFG_FIRST_END_CHAR:  r_first_end_char  <= i_cfg_data;
                accfp_pkg::CFG_SECOND_END_CHAR: r_second_end_char <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state
    accfp_pkg::t_state r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_m_valid, n_m_valid;
    logic [BW-1:0]     r_m_byte, n_m_byte;
    logic              r_m_last, n_m_last;
    logic [LW-1:0]     r_m_len, n_m_len;

    logic              w_in_acc;
    logic              w_load;
    logic              w_more;
    logic              w_is_start, w_is_end1, w_is_end2;
    logic              w_store;
    logic              w_shift;
    logic [BW-1:0]     w_cell_q [N];

    assign s_axis_tready = (r_state != accfp_pkg::ST_EMIT);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_load        = !r_m_valid || m_axis_tready;
    assign w_more        = (r_idx < r_count);
    assign w_is_start    = (s_axis_tdata == r_start_char);
    assign w_is_end1     = (s_axis_tdata == r_first_end_char);
    assign w_is_end2     = (s_axis_tdata == r_second_end_char);

    // Next phase
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            accfp_pkg::ST_HUNT: begin
                if (w_in_acc && w_is_start) n_state = accfp_pkg::ST_DATA;
            end
            accfp_pkg::ST_DATA: begin
                if (w_in_acc && w_is_end1) n_state = accfp_pkg::ST_END;
            end
            accfp_pkg::ST_END: begin
                if (w_in_acc) begin
                    n_state = w_is_end2 ? accfp_pkg::ST_EMIT : accfp_pkg::ST_HUNT;
                end
            end
            accfp_pkg::ST_EMIT: begin
                if (w_load && !w_more) n_state = accfp_pkg::ST_HUNT;
            end
            default: n_state = accfp_pkg::ST_HUNT;
        endcase
    end

    // Count, drain index, cell control and output register
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_m_valid = r_m_valid;
        n_m_byte  = r_m_byte;
        n_m_last  = r_m_last;
        n_m_len   = r_m_len;
        w_store   = 1'b0;
        w_shift   = 1'b0;
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        unique case (r_state)
            accfp_pkg::ST_HUNT: begin
                if (w_in_acc && w_is_start) n_count = '0;
            end
            accfp_pkg::ST_DATA: begin
                if (w_in_acc && !w_is_end1 && (r_count < CW'(N))) begin
                    w_store = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            accfp_pkg::ST_END: begin
                n_idx = '0;
                if (w_in_acc && !w_is_end2) n_count = '0;
            end
            accfp_pkg::ST_EMIT: begin
                if (w_load) begin
                    n_m_valid = 1'b1;
                    n_m_len   = LW'(r_count);
                    if (w_more) begin
                        // drop the head byte out, advance the row
                        n_m_byte = w_cell_q[0];
                        n_m_last = 1'b0;
                        w_shift  = 1'b1;
                        n_idx    = r_idx + CW'(1);
                    end else begin
                        // close the frame with the terminator beat
                        n_m_byte = '0;
                        n_m_last = 1'b1;
                        n_count  = '0;
                        n_idx    = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= accfp_pkg::ST_HUNT;
            r_count   <= '0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_byte <= n_m_byte;
        r_m_last <= n_m_last;
        r_m_len  <= n_m_len;
    end

    // Row of byte cells: write at the fill position, drain towards cell 0
    for (genvar k = 0; k < N; k++) begin : g_cell
        accfp_pkg::t_cell_ctl w_ctl;
        logic [BW-1:0]        w_next;

        assign w_ctl.load  = w_store && (r_count == CW'(k));
        assign w_ctl.shift = w_shift;

        if (k == N - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell_q[k+1];
        end

        accfp_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_byte (s_axis_tdata),
            .i_next (w_next),
            .o_byte (w_cell_q[k])
        );
    end

    // Output beat
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = {(accfp_pkg::OUT_TDATA_W - LW - BW)'(0), r_m_len, r_m_byte};

endmodule
